// ----- rtl/adbd_pkg.sv -----
package adbd_pkg;

   // Block layout: two scale bytes, then sixteen residual bytes
   localparam int BlockBytes  = 18;
   localparam int PosW        = 5;
   localparam logic [PosW-1:0] PosScaleHi = PosW'(0);
   localparam logic [PosW-1:0] PosScaleLo = PosW'(1);
   localparam logic [PosW-1:0] PosFirstResid = PosW'(2);
   localparam logic [PosW-1:0] PosLast   = PosW'(BlockBytes - 1);

   // Bit of the completed scale that marks the end of the stream (0x8000)
   localparam int EndFlagBit  = 15;

   localparam int SampleW     = 16;
   localparam int CoeffW      = 16;
   localparam int ScaleW      = 16;
   localparam int ChanCountW  = 2;
   localparam int NumHist     = 2;
   localparam int MaxChannels = 2;

   localparam int CsrAddrW    = 4;
   localparam int CsrDataW    = 32;

   typedef enum logic [1:0] {
      RegCoeffRecent = 2'd0,
      RegCoeffOlder  = 2'd1,
      RegNumChannels = 2'd2
   } reg_index_type;

   typedef enum logic {
      ReqStream = 1'b0,
      ReqFlush  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic signed [CoeffW-1:0] coeff_recent;
      logic signed [CoeffW-1:0] coeff_older;
      logic [ChanCountW-1:0]    num_channels;
   } cfg_type;

   // Two channels are active for a count of 2 or 3, limited by MaxChannels
   function automatic logic two_channels(input logic [ChanCountW-1:0] count);
      return count[1] && (MaxChannels >= 2);
   endfunction

endpackage

// ----- rtl/adpcm_block_decoder_2nd_order.sv -----
// Channel  Direction  Payload
// req      in         tdata[7:0] data_byte; tuser[0] req_type (1 = flush)
// rsp      out        tdata[15:0] sample; tuser[0] channel, tuser[1] end_of_stream;
//                     tlast = last result of the input byte
// csr      in/out     APB registers: 0x0 coeff_recent, 0x4 coeff_older, 0x8 num_channels
//
// A scale byte, a flush or an ignored byte leaves the work stage when its step is taken.
// A residual byte stays for its second nibble; each nibble goes through one predictor
// step with its two 16x16 multiplies; its two results share one result port.
// Reset clears the stream state, history and the registers (num_channels to 1).
// A full result register stalls only work that produces a result.
module adpcm_block_decoder_2nd_order
   import adbd_pkg::*;
#(
   parameter int COEFF_SHIFT = 12
)
(
   input  logic                clock,
   input  logic                reset,
   // input stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tuser,   // [0] req_type
   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [15:0] sample
   output logic [1:0]          rsp_tuser,   // [0] channel, [1] end_of_stream
   output logic                rsp_tlast,
   // configuration
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   cfg_type cfg;

   // Work stage: holds one accepted transfer until its last result is loaded into the result register
   logic               stage_valid_ff, stage_valid_in;
   req_kind_type       stage_kind_ff, stage_kind_in;
   logic [7:0]         stage_byte_ff, stage_byte_in;
   logic               phase_ff, phase_in;

   // Stream state
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [ScaleW-1:0]  scale_ff, scale_in;
   logic               chan_ff, chan_in;
   logic               end_ff, end_in;
   logic signed [SampleW-1:0] hist_recent_ff [NumHist];
   logic signed [SampleW-1:0] hist_recent_in [NumHist];
   logic signed [SampleW-1:0] hist_older_ff  [NumHist];
   logic signed [SampleW-1:0] hist_older_in  [NumHist];

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SampleW-1:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_chan_ff, rsp_chan_in;
   logic               rsp_eos_ff, rsp_eos_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_space;
   logic               is_resid;
   logic               eos_hit;
   logic               emits;
   logic               step;
   logic               consume;
   logic               load_out;
   logic [ScaleW-1:0]  full_scale;
   logic [3:0]         nibble;
   logic signed [SampleW-1:0] pred_sample;

   adbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // High nibble first, low nibble on the second pass
   assign nibble = phase_ff ? stage_byte_ff[3:0] : stage_byte_ff[7:4];

   adbd_predictor #(
      .COEFF_SHIFT (COEFF_SHIFT)
   ) u_predictor (
      .coeff_recent (cfg.coeff_recent),
      .coeff_older  (cfg.coeff_older),
      .hist_recent  (hist_recent_ff[chan_ff]),
      .hist_older   (hist_older_ff[chan_ff]),
      .scale        (scale_ff),
      .nibble       (nibble),
      .sample       (pred_sample)
   );

   assign out_space  = !rsp_valid_ff || rsp_tready;
   assign is_resid   = (pos_ff >= PosFirstResid);
   assign full_scale = {scale_ff[ScaleW-1:8], stage_byte_ff};
   assign eos_hit    = (pos_ff == PosScaleLo) && full_scale[EndFlagBit];

   // Only a residual nibble or the end marker produces a result
   assign emits    = stage_valid_ff && (stage_kind_ff == ReqStream) && !end_ff
                     && (is_resid || eos_hit);
   assign step     = stage_valid_ff && (!emits || out_space);
   // A residual byte stays in the stage for its second nibble
   assign consume  = step && !(emits && is_resid && !phase_ff);
   assign load_out = step && emits;

   assign req_tready = !stage_valid_ff || consume;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_kind_in  = stage_kind_ff;
      stage_byte_in  = stage_byte_ff;
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      scale_in       = scale_ff;
      chan_in        = chan_ff;
      end_in         = end_ff;
      hist_recent_in = hist_recent_ff;
      hist_older_in  = hist_older_ff;

      // Work stage: drop on completion, load on a new transfer
      if (consume) begin
         stage_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
         stage_kind_in  = req_kind_type'(req_tuser);
         stage_byte_in  = req_tdata;
      end
      if (load_out && is_resid) begin
         phase_in = !phase_ff;
      end

      if (step) begin
         if (stage_kind_ff == ReqFlush) begin
            // flush: clear the stream, keep the registers
            pos_in   = '0;
            scale_in = '0;
            chan_in  = 1'b0;
            end_in   = 1'b0;
            for (int i = 0; i < NumHist; i++) begin
               hist_recent_in[i] = '0;
               hist_older_in[i]  = '0;
            end
         end else if (end_ff) begin
            // after the end marker: ignore stream bytes
         end else if (pos_ff == PosScaleHi) begin
            scale_in = {stage_byte_ff, 8'h00};
            pos_in   = PosScaleLo;
         end else if (pos_ff == PosScaleLo) begin
            scale_in = full_scale;
            if (eos_hit) begin
               end_in = 1'b1;
            end else begin
               pos_in = PosFirstResid;
            end
         end else begin
            hist_older_in[chan_ff]  = hist_recent_ff[chan_ff];
            hist_recent_in[chan_ff] = pred_sample;
            if (phase_ff) begin
               // second nibble done: advance, close the block at its last byte
               if (pos_ff >= PosLast) begin
                  pos_in  = '0;
                  chan_in = two_channels(cfg.num_channels) ? !chan_ff : 1'b0;
               end else begin
                  pos_in = pos_ff + PosW'(1);
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_eos_in    = rsp_eos_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = eos_hit ? '0 : pred_sample;
         rsp_chan_in   = chan_ff;
         rsp_eos_in    = eos_hit;
         rsp_last_in   = eos_hit || phase_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= 1'b0;
         pos_ff         <= '0;
         scale_ff       <= '0;
         chan_ff        <= 1'b0;
         end_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NumHist; i++) begin
            hist_recent_ff[i] <= '0;
            hist_older_ff[i]  <= '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         scale_ff       <= scale_in;
         chan_ff        <= chan_in;
         end_ff         <= end_in;
         rsp_valid_ff   <= rsp_valid_in;
         hist_recent_ff <= hist_recent_in;
         hist_older_ff  <= hist_older_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      stage_kind_ff <= stage_kind_in;
      stage_byte_ff <= stage_byte_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_eos_ff    <= rsp_eos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = {rsp_eos_ff, rsp_chan_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // The end marker carries a zero sample and closes its transfer group
   a_eos_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eos_ff) |-> (rsp_sample_ff == '0 && rsp_last_ff))
      else $error("end marker with nonzero sample or without last");

   // Position never runs past the last byte of a block
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosLast)
      else $error("byte position beyond block");

   // Second nibble pending only for a live residual byte in the stage
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (stage_valid_ff && stage_kind_ff == ReqStream && is_resid && !end_ff))
      else $error("second nibble pending without a residual byte");

   // A taken high nibble of a residual byte leaves its low nibble pending
   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      (load_out && is_resid && !phase_ff) |=> phase_ff)
      else $error("low nibble not scheduled after high nibble");
`endif

endmodule

// ----- rtl/adbd_csr.sv -----
module adbd_csr
   import adbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready,
   output cfg_type             cfg
);

   logic signed [CoeffW-1:0] coeff_recent_ff, coeff_recent_in;
   logic signed [CoeffW-1:0] coeff_older_ff, coeff_older_in;
   logic [ChanCountW-1:0]    num_channels_ff, num_channels_in;
   reg_index_type            reg_index;
   logic                     wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      coeff_recent_in = coeff_recent_ff;
      coeff_older_in  = coeff_older_ff;
      num_channels_in = num_channels_ff;
      if (wr_en) begin
         case (reg_index)
            RegCoeffRecent: coeff_recent_in = csr_pwdata[CoeffW-1:0];
            RegCoeffOlder:  coeff_older_in  = csr_pwdata[CoeffW-1:0];
            RegNumChannels: num_channels_in = csr_pwdata[ChanCountW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_recent_ff <= '0;
         coeff_older_ff  <= '0;
         num_channels_ff <= ChanCountW'(1);
      end else begin
         coeff_recent_ff <= coeff_recent_in;
         coeff_older_ff  <= coeff_older_in;
         num_channels_ff <= num_channels_in;
      end
   end

   always_comb begin
      case (reg_index)
         RegCoeffRecent: csr_prdata = CsrDataW'(unsigned'(coeff_recent_ff));
         RegCoeffOlder:  csr_prdata = CsrDataW'(unsigned'(coeff_older_ff));
         RegNumChannels: csr_prdata = CsrDataW'(num_channels_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.coeff_recent = coeff_recent_ff;
   assign cfg.coeff_older  = coeff_older_ff;
   assign cfg.num_channels = num_channels_ff;

endmodule

// ----- rtl/adbd_predictor.sv -----
module adbd_predictor
   import adbd_pkg::*;
#(
   parameter int COEFF_SHIFT = 12
)
(
   input  logic signed [CoeffW-1:0]  coeff_recent,
   input  logic signed [CoeffW-1:0]  coeff_older,
   input  logic signed [SampleW-1:0] hist_recent,
   input  logic signed [SampleW-1:0] hist_older,
   input  logic [ScaleW-1:0]         scale,
   input  logic [3:0]                nibble,
   output logic signed [SampleW-1:0] sample
);

   localparam int ProdW  = CoeffW + SampleW;
   localparam int PredW  = ProdW + 1;
   localparam int ResidW = ScaleW + 5;
   localparam int SumW   = PredW + 1;
   localparam logic signed [SumW-1:0] SatMax = SumW'(32767);
   localparam logic signed [SumW-1:0] SatMin = SumW'(-32768);

   logic signed [ProdW-1:0]  prod_recent;
   logic signed [ProdW-1:0]  prod_older;
   logic signed [PredW-1:0]  pred_sum;
   logic signed [PredW-1:0]  pred_shift;
   logic signed [ResidW-1:0] resid_term;
   logic signed [SumW-1:0]   total;

   assign prod_recent = coeff_recent * hist_recent;
   assign prod_older  = coeff_older * hist_older;
   assign pred_sum    = PredW'(prod_recent) + PredW'(prod_older);
   assign pred_shift  = pred_sum >>> COEFF_SHIFT;

   // residual is a signed nibble, scale is unsigned
   assign resid_term  = ResidW'($signed(nibble)) * ResidW'($signed({1'b0, scale}));
   assign total       = SumW'(pred_shift) + SumW'(resid_term);

   always_comb begin
      if (total > SatMax) begin
         sample = SatMax[SampleW-1:0];
      end else if (total < SatMin) begin
         sample = SatMin[SampleW-1:0];
      end else begin
         sample = total[SampleW-1:0];
      end
   end

endmodule
